/* design/dhst_pkg.sv */
package dhst_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SIZE_W     = 7;
    localparam int NAME_CHARS = 8;
    localparam int CHARS_W    = 8 * NAME_CHARS;
    localparam int LEN_W      = 4;
    localparam int KEY_W      = 16;
    localparam int ENTRY_W    = CHARS_W + LEN_W + 2;
    localparam int ERR_W      = 16;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_UNDECL    = 3'd2,
        ST_FOUND     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_CHECK,
        S_DONE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mod_step;
        logic probe_rd;
        logic advance;
        logic finish;
        logic out_take;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic slot_empty;
        logic slot_match;
        logic probes_done;
        logic size_zero;
        logic out_valid;
    } dp_stat_t;

endpackage

/* design/double_hash_symbol_table.sv */
// Channel  Dir  tdata fields (low bit up)                              tuser
// s_axis   in   name_chars[63:0], name_length[67:64], type_code[69:68] is_declaration
// m_axis   out  status[2:0], slot_index[8:3], home_slot[14:9],
//               error_total[30:15] (tdata 32 bits)                     none
// cfg      in   cfg_wr_data = table_size (7 bits)
// One item at a time: a bit-serial remainder for home slot and step, then
// an S_PROBE and an S_CHECK state per probe (table RAM registered read),
// then finish and output.
// Synchronous active-low reset empties all slots and zeroes the error count;
// table_size resets to 1. Result waits in the output register until taken.
module double_hash_symbol_table
    import dhst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [71:0]       s_axis_tdata,  // name_chars, name_length, type_code
    input  logic              s_axis_tuser,  // is_declaration
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata   // status, slot_index, home_slot, error_total
);

    logic [SIZE_W-1:0] size_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              in_fire, out_fire;
    logic [2:0]        o_st;
    logic [SLOT_W-1:0] o_slot, o_home;
    logic [ERR_W-1:0]  o_err;

    always_ff @(posedge aclk) begin
        if (!aresetn)       size_reg <= SIZE_W'(1);
        else if (cfg_wr_en) size_reg <= cfg_wr_data;
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    dhst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .in_ready(s_axis_tready)
    );

    dhst_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .size_cfg(size_reg),
        .in_chars(s_axis_tdata[63:0]), .in_len(s_axis_tdata[67:64]),
        .in_decl(s_axis_tuser), .in_type(s_axis_tdata[69:68]),
        .out_status(o_st), .out_slot(o_slot), .out_home(o_home), .out_errors(o_err)
    );

    assign m_axis_tvalid = stat.out_valid;
    assign m_axis_tdata  = {1'b0, o_err, o_home, o_slot, o_st};

    // result never shown while taking input
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");
    // accepted item leads to no immediate result
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !m_axis_tvalid) else $error("result too early");
    // status codes stay in range
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4) else $error("bad status");

endmodule

/* design/dhst_ram.sv */
module dhst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/dhst_datapath.sv */
module dhst_datapath
    import dhst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [SIZE_W-1:0]  size_cfg,
    input  logic [CHARS_W-1:0] in_chars,
    input  logic [LEN_W-1:0]   in_len,
    input  logic               in_decl,
    input  logic [1:0]         in_type,
    output logic [2:0]         out_status,
    output logic [SLOT_W-1:0]  out_slot,
    output logic [SLOT_W-1:0]  out_home,
    output logic [ERR_W-1:0]   out_errors
);

    logic [SIZE_W-1:0]  m_reg, m_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               decl_reg, decl_next;
    logic [1:0]         type_reg, type_next;
    // restoring remainders, one key bit per cycle, both moduli at once
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SIZE_W-1:0]  rh_reg, rh_next, rs_reg, rs_next;
    logic [4:0]         bit_reg, bit_next;
    logic [SLOT_W-1:0]  home_reg, home_next, step_reg, step_next, idx_reg, idx_next;
    logic [SIZE_W-1:0]  cnt_reg, cnt_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [2:0]         st_reg, st_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic               oval_reg, oval_next;

    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [SIZE_W-1:0]  m_sat, ms, th, ts;
    logic [SIZE_W:0]    sh, ss;
    logic [CHARS_W-1:0] masked;
    logic [KEY_W-1:0]   key_c;
    logic [3:0]         len_sat;
    logic [SIZE_W:0]    nidx;
    logic               found;

    assign m_sat   = (size_cfg > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : size_cfg;
    assign len_sat = (in_len > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : in_len;
    assign ms      = (m_reg > 7'd3) ? m_reg - 7'd3 : m_reg;

    // Horner key and byte mask
    always_comb begin
        key_c  = '0;
        masked = '0;
        for (int k = 0; k < NAME_CHARS; k++) begin
            if (4'(k) < len_sat) begin
                masked[8*k +: 8] = in_chars[8*k +: 8];
                key_c = {key_c[KEY_W-2:0], 1'b0} + KEY_W'(in_chars[8*k +: 8]);
            end
        end
    end

    always_comb begin
        sh = {rh_reg, key_reg[KEY_W-1]};
        ss = {rs_reg, key_reg[KEY_W-1]};
        th = (sh >= {1'b0, m_reg}) ? SIZE_W'(sh - {1'b0, m_reg}) : sh[SIZE_W-1:0];
        ts = (ss >= {1'b0, ms}) ? SIZE_W'(ss - {1'b0, ms}) : ss[SIZE_W-1:0];
    end

    assign found = used_reg[idx_reg] && rd_data[CHARS_W +: LEN_W] == len_reg
                   && rd_data[CHARS_W-1:0] == chars_reg;
    assign nidx  = (SIZE_W+1)'(idx_reg) + (SIZE_W+1)'(step_reg);

    always_comb begin
        m_next = m_reg; chars_next = chars_reg; len_next = len_reg;
        decl_next = decl_reg; type_next = type_reg; key_next = key_reg;
        rh_next = rh_reg; rs_next = rs_reg; bit_next = bit_reg;
        home_next = home_reg; step_next = step_reg; idx_next = idx_reg;
        cnt_next = cnt_reg; used_next = used_reg; err_next = err_reg;
        st_next = st_reg; pos_next = pos_reg; oval_next = oval_reg;
        wr_en = 1'b0;
        if (cmd.load) begin
            m_next = m_sat; chars_next = masked; len_next = len_sat;
            decl_next = in_decl; type_next = in_type; key_next = key_c;
            rh_next = '0; rs_next = '0; bit_next = '0;
        end
        if (cmd.mod_step) begin
            rh_next  = th; rs_next = ts;
            key_next = {key_reg[KEY_W-2:0], 1'b0};
            bit_next = bit_reg + 5'd1;
            if (bit_reg == 5'(KEY_W-1)) begin
                home_next = SLOT_W'(th);
                idx_next  = SLOT_W'(th);
                // step is below 2m, reduce once
                step_next = SLOT_W'(((ts + 7'd1) >= m_reg) ? ts + 7'd1 - m_reg : ts + 7'd1);
                cnt_next  = '0;
            end
        end
        if (cmd.advance) begin
            idx_next = (nidx >= {1'b0, m_reg}) ? SLOT_W'(nidx - {1'b0, m_reg})
                                                : SLOT_W'(nidx);
            cnt_next = cnt_reg + 7'd1;
        end
        if (cmd.finish) begin
            oval_next = 1'b1;
            pos_next  = '0;
            if (m_reg == '0) begin
                home_next = '0;
                st_next = decl_reg ? ST_FULL : ST_UNDECL;
            end else if (found) begin
                st_next = decl_reg ? ST_DUPLICATE : ST_FOUND;
                pos_next = idx_reg;
            end else if (!used_reg[idx_reg] && cnt_reg < m_reg) begin
                st_next = decl_reg ? ST_INSERTED : ST_UNDECL;
                if (decl_reg) begin
                    pos_next = idx_reg;
                    wr_en = 1'b1;
                    used_next[idx_reg] = 1'b1;
                end
            end else begin
                st_next = decl_reg ? ST_FULL : ST_UNDECL;
            end
            if ((st_next == ST_DUPLICATE || st_next == ST_UNDECL) && err_reg != '1) begin
                err_next = err_reg + 16'd1;
            end
        end
        if (cmd.out_take) oval_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0; err_reg <= '0; oval_reg <= 1'b0; m_reg <= '0;
        end else begin
            used_reg <= used_next; err_reg <= err_next; oval_reg <= oval_next;
            m_reg <= m_next;
        end
        chars_reg <= chars_next; len_reg <= len_next; decl_reg <= decl_next;
        type_reg <= type_next; key_reg <= key_next; rh_reg <= rh_next;
        rs_reg <= rs_next; bit_reg <= bit_next; home_reg <= home_next;
        step_reg <= step_next; idx_reg <= idx_next; cnt_reg <= cnt_next;
        st_reg <= st_next; pos_reg <= pos_next;
    end

    dhst_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data ({type_reg, len_reg, chars_reg}),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign stat.mod_done    = (bit_reg == 5'(KEY_W-1));
    assign stat.slot_empty  = !used_reg[idx_reg];
    assign stat.slot_match  = found;
    assign stat.probes_done = (cnt_reg + 7'd1 >= m_reg);
    assign stat.size_zero   = (m_reg == '0);
    assign stat.out_valid   = oval_reg;

    assign out_status = st_reg;
    assign out_slot   = pos_reg;
    assign out_home   = home_reg;
    assign out_errors = err_reg;

endmodule

/* design/dhst_ctrl.sv */
module dhst_ctrl
    import dhst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_fire,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     in_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_MOD;
            S_MOD:   if (stat.mod_done) state_next = stat.size_zero ? S_DONE : S_PROBE;
            S_PROBE: state_next = S_CHECK;
            S_CHECK: begin
                if (stat.slot_empty || stat.slot_match || stat.probes_done)
                    state_next = S_DONE;
                else
                    state_next = S_PROBE;
            end
            S_DONE:  state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:  begin in_ready = 1'b1; cmd.load = in_fire; end
            S_MOD:   cmd.mod_step = 1'b1;
            S_PROBE: cmd.probe_rd = 1'b1;
            S_CHECK: cmd.advance = !(stat.slot_empty || stat.slot_match
                                     || stat.probes_done);
            S_DONE:  cmd.finish = 1'b1;
            S_OUT:   cmd.out_take = out_fire;
            default: ;
        endcase
    end

endmodule
